>>> design/g711_companding_codec_defines.svh
// Assertion macros for the G.711 companding codec.
// Included by files that carry concurrent checks; expects clk and rst_n in scope.
`ifndef G711_COMPANDING_CODEC_DEFINES_SVH
`define G711_COMPANDING_CODEC_DEFINES_SVH

// same-cycle implication
`define G711_ASSERT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define G711_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> design/g711_pkg.sv
// Shared types, constants and level/threshold tables for the G.711 codec.
// No dependencies; used by g711_search_step and g711_companding_codec.
package g711_pkg;

    localparam int MAG_W  = 13;
    localparam int THR_W  = 13;
    localparam int IDX_W  = 14;
    localparam int LVL_W  = 15;
    localparam int CODE_W = 8;
    localparam int SAMP_W = 16;
    localparam int MIDX_W = 7;
    localparam int THR_N  = 127;

    localparam logic [CODE_W-1:0] MASK_ALAW = 8'hd5;
    localparam logic [CODE_W-1:0] MASK_ULAW = 8'hff;
    localparam logic [CODE_W-1:0] CODE_SIGN = 8'h80;
    localparam logic [LVL_W-1:0]  ULAW_BIAS = 15'h84;
    localparam logic [LVL_W-1:0]  ALAW_SEG_OFS = 15'd32;
    localparam logic [IDX_W-1:0]  IDX_CENTRE = 14'd8192;

    typedef enum logic {LAW_A = 1'b0, LAW_U = 1'b1} law_t;
    typedef enum logic {OP_ENCODE = 1'b0, OP_DECODE = 1'b1} op_t;

    typedef logic [THR_N-1:0][THR_W-1:0] thr_tbl_t;

    // one word in flight through the search pipeline
    typedef struct packed {
        logic              valid;
        op_t               op;
        law_t              law;
        logic              last;
        logic              neg;
        logic [MAG_W-1:0]  mag;
        logic [MIDX_W-1:0] code;
        logic              dec_pos;
        logic [MIDX_W-1:0] dec_idx;
    } stg_t;

    // positive reconstruction level of magnitude code i (segment, mantissa)
    function automatic logic [LVL_W-1:0] level(input logic [MIDX_W-1:0] i, input law_t law);
        logic [2:0]       seg;
        logic [3:0]       mant;
        logic [LVL_W-1:0] base;
        logic [LVL_W-1:0] res;
        seg = i[6:4];
        mant = i[3:0];
        if (law == LAW_A)
        begin
            base = LVL_W'({mant, 1'b1});
            if (seg == 3'd0)
                res = base << 3;
            else
                res = ((base + ALAW_SEG_OFS) << 2) << seg;
        end
        else
        begin
            base = LVL_W'({mant, 3'b000});
            res = ((base + ULAW_BIAS) << seg) - ULAW_BIAS;
        end
        return res;
    endfunction

    // decision thresholds: midpoint of neighbouring levels, in index units
    function automatic thr_tbl_t build_thr(input law_t law);
        logic [LVL_W+1:0] sum;
        thr_tbl_t         t;
        for (int i = 0; i < THR_N; i++)
        begin
            sum = (LVL_W+2)'(level(MIDX_W'(i), law)) + (LVL_W+2)'(level(MIDX_W'(i + 1), law))
                + (LVL_W+2)'(4);
            t[i] = THR_W'(sum >> 3);
        end
        return t;
    endfunction

    localparam thr_tbl_t THR_ALAW = build_thr(LAW_A);
    localparam thr_tbl_t THR_ULAW = build_thr(LAW_U);

endpackage

>>> design/g711_search_step.sv
// One step of the threshold binary search: decides one bit of the magnitude code.
// Depends on g711_pkg (stage type and threshold tables).
module g711_search_step (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            en,
    input  logic [2:0]      bit_pos,
    input  g711_pkg::stg_t  stg_in,
    output g711_pkg::stg_t  stg_out
);
    import g711_pkg::*;

    stg_t              stg_reg;
    stg_t              stg_next;
    logic [MIDX_W-1:0] cand;
    logic [MIDX_W-1:0] tidx;
    logic [THR_W-1:0]  thr;

    // lower bits still zero, so cand - 1 never exceeds the last threshold
    always_comb
    begin
        cand = stg_in.code | (MIDX_W'(1) << bit_pos);
        tidx = cand - MIDX_W'(1);
        thr = (stg_in.law == LAW_U) ? THR_ULAW[tidx] : THR_ALAW[tidx];
        stg_next = stg_in;
        if (thr <= stg_in.mag)
            stg_next.code = cand;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            stg_reg <= '0;
        else if (en)
            stg_reg <= stg_next;
    end

    assign stg_out = stg_reg;

endmodule

>>> design/g711_companding_codec.sv
// Top level of the G.711 A-law / mu-law companding codec.
// Depends on g711_pkg, g711_search_step and g711_companding_codec_defines.svh.

// Takes one word per clock when the output side is not stalled and returns one
// word per input word, in order. The encoder finds the nearest code by a
// seven-step binary search over the decision thresholds, one register stage
// per code bit, between an input stage and an output stage; a stall on the
// output holds the whole pipeline. law_select (cfg_we/cfg_wdata) must only
// change while the pipeline is empty.
module g711_companding_codec (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic        cfg_wdata,      // law_select: 0 A-law, 1 mu-law
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // [15:0] sample_in, [23:16] code_in
    input  logic        s_axis_tuser,   // mode: 0 encode, 1 decode
    input  logic        s_axis_tlast,   // last_in
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // [7:0] code_out, [23:8] sample_out
    output logic        m_axis_tlast    // last_out
);
    import g711_pkg::*;
    `include "g711_companding_codec_defines.svh"

    localparam int STEPS = MIDX_W;

    typedef struct packed {
        logic              valid;
        logic [CODE_W-1:0] code;
        logic [SAMP_W-1:0] sample;
        logic              last;
    } out_t;

    law_t             law_reg;
    stg_t             stg_a_reg;
    stg_t             stg_a_next;
    stg_t             chain [STEPS+1];
    out_t             out_reg;
    out_t             out_next;
    logic             pipe_en;
    logic [IDX_W-1:0] idx;
    logic [CODE_W-1:0] mask;
    logic [CODE_W-1:0] enc_code;
    logic [LVL_W-1:0] lvl;
    logic [SAMP_W-1:0] dec_smp;

    assign pipe_en = !out_reg.valid || m_axis_tready;
    assign s_axis_tready = pipe_en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            law_reg <= LAW_A;
        else if (cfg_we)
            law_reg <= law_t'(cfg_wdata);
    end

    // input stage: offset index, distance from centre, decode prep
    always_comb
    begin
        idx = {~s_axis_tdata[15], s_axis_tdata[14:2]};
        if (idx == '0)
            idx = IDX_W'(1);
        stg_a_next.valid = s_axis_tvalid;
        stg_a_next.op = op_t'(s_axis_tuser);
        stg_a_next.law = law_reg;
        stg_a_next.last = s_axis_tlast;
        stg_a_next.neg = (idx < IDX_CENTRE);
        stg_a_next.mag = (idx < IDX_CENTRE) ? MAG_W'(IDX_CENTRE - idx) : MAG_W'(idx - IDX_CENTRE);
        stg_a_next.code = '0;
        // stored sign bit is 1 for a positive sample under both laws, so it is used as is
        stg_a_next.dec_pos = s_axis_tdata[23];
        if (law_reg == LAW_U)
            stg_a_next.dec_idx = ~s_axis_tdata[22:16];
        else
            stg_a_next.dec_idx = s_axis_tdata[22:16] ^ MASK_ALAW[6:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            stg_a_reg <= '0;
        else if (pipe_en)
            stg_a_reg <= stg_a_next;
    end

    assign chain[0] = stg_a_reg;

    for (genvar k = 0; k < STEPS; k++)
    begin : g_step
        g711_search_step u_step (
            .clk     (clk),
            .rst_n   (rst_n),
            .en      (pipe_en),
            .bit_pos (3'(STEPS - 1 - k)),
            .stg_in  (chain[k]),
            .stg_out (chain[k+1])
        );
    end

    // output stage: apply law mask and sign, or expand decoded level
    always_comb
    begin
        mask = (chain[STEPS].law == LAW_U) ? MASK_ULAW : MASK_ALAW;
        enc_code = {1'b0, chain[STEPS].code} ^ mask ^ (chain[STEPS].neg ? CODE_SIGN : '0);
        lvl = level(chain[STEPS].dec_idx, chain[STEPS].law);
        dec_smp = chain[STEPS].dec_pos ? {1'b0, lvl} : SAMP_W'(-{1'b0, lvl});
        out_next.valid = chain[STEPS].valid;
        out_next.last = chain[STEPS].last;
        out_next.code = (chain[STEPS].op == OP_ENCODE) ? enc_code : '0;
        out_next.sample = (chain[STEPS].op == OP_DECODE) ? dec_smp : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_reg <= '0;
        else if (pipe_en)
            out_reg <= out_next;
    end

    assign m_axis_tvalid = out_reg.valid;
    assign m_axis_tdata = {out_reg.sample, out_reg.code};
    assign m_axis_tlast = out_reg.last;

    `G711_ASSERT(a_one_field, m_axis_tvalid, m_axis_tdata[7:0] == 8'h00 || m_axis_tdata[23:8] == 16'h0000, "both result fields non-zero")
    `G711_ASSERT_NEXT(a_accept_enters, s_axis_tvalid && s_axis_tready, stg_a_reg.valid, "accepted word did not enter pipeline")
    `G711_ASSERT_NEXT(a_stall_holds, !pipe_en, $stable(chain[STEPS]), "search pipeline moved during stall")
    `G711_ASSERT(a_code_clear, stg_a_reg.valid, stg_a_reg.code == '0, "search started with non-zero code")

endmodule
